### rtl/core/tap_dance_key_resolver_defines.svh
// Assertion macros used by the checker file.
`ifndef TAP_DANCE_KEY_RESOLVER_DEFINES_SVH
`define TAP_DANCE_KEY_RESOLVER_DEFINES_SVH

// Same-cycle implication, switched off while dis is high.
`define TDKR_ASSERT_NOW(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while dis is high.
`define TDKR_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tdkr_pkg.sv
package tdkr_pkg;

  localparam int CODE_W      = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int LAYER_COUNT = 4;

  localparam logic [1:0] FUNC_PRESS   = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_TICK    = 2'd2;
  localparam logic [1:0] FUNC_FOREIGN = 2'd3;

  localparam logic [1:0] CODE_TAP      = 2'd0;
  localparam logic [1:0] CODE_HOLD     = 2'd1;
  localparam logic [1:0] CODE_DOUBLE   = 2'd2;
  localparam logic [1:0] CODE_TAP_HOLD = 2'd3;

  localparam logic [7:0] MO_PREFIX     = 8'h52;
  localparam logic [7:0] LT_MASK       = 8'hF0;
  localparam logic [7:0] LT_PREFIX     = 8'h40;
  localparam logic [7:0] LT_LAYER_MASK = 8'h0F;
  localparam logic [4:0] LAYER_MASK    = 5'h1F;
  localparam logic [7:0] TERM_TICKS    = 8'd3;
  localparam logic [3:0] PEND_POLLS    = 4'd10;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] key_index;
    logic [7:0] now_ticks;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pending_key;
    logic [4:0] hold_layer;
    logic       dance_open;
  } out_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] tap;
    logic [CODE_W-1:0] hold;
    logic [CODE_W-1:0] dbl;
    logic [CODE_W-1:0] tap_hold;
  } entry_codes_t;

  typedef struct packed {
    logic       active_valid;
    logic       active_entry;
    logic       key_down;
    logic [1:0] tap_count;
    logic [7:0] start_tick;
    logic [7:0] held_key;
    logic [7:0] pending_tap;
    logic [3:0] pending_polls;
    logic [4:0] layer_held;
  } dance_state_t;

endpackage

### rtl/core/tdkr_step.sv
module tdkr_step import tdkr_pkg::*; #(
  parameter int ENTRY_COUNT = 2
) (
  input  dance_state_t cur,
  input  in_item_t     item,
  input  entry_codes_t codes,
  output dance_state_t nxt,
  output out_item_t    result
);

  logic [CODE_W-1:0] hold_kc;
  logic [CODE_W-1:0] tap_kc;
  logic [7:0]        hold_hi;
  logic [4:0]        hold_nl;
  logic              hold_is_layer;
  logic              hold_is_key;
  logic              tap_is_key;
  logic [7:0]        elapsed;
  logic              term_over;
  logic              same_entry;
  logic              do_settle;
  logic              do_emit;
  logic              do_count;
  dance_state_t      mid;

  always_comb begin
    if (cur.tap_count >= 2'd2 && codes.tap_hold != '0) begin
      hold_kc = codes.tap_hold;
    end else if (codes.hold != '0) begin
      hold_kc = codes.hold;
    end else begin
      hold_kc = codes.tap;
    end
    hold_hi = hold_kc[15:8];
    if (hold_hi == MO_PREFIX) begin
      hold_nl = hold_kc[4:0] & LAYER_MASK;
    end else if ((hold_hi & LT_MASK) == LT_PREFIX) begin
      hold_nl = 5'(hold_hi & LT_LAYER_MASK);
    end else begin
      hold_nl = '0;
    end
    hold_is_layer = (hold_nl != '0) && ({1'b0, hold_nl} < 6'(LAYER_COUNT));
    hold_is_key   = (hold_kc != '0) && (hold_hi == '0);

    if (cur.tap_count >= 2'd2 && codes.dbl != '0) begin
      tap_kc = codes.dbl;
    end else begin
      tap_kc = codes.tap;
    end
    tap_is_key = (tap_kc != '0) && (tap_kc[15:8] == '0);

    elapsed    = item.now_ticks - cur.start_tick;
    term_over  = elapsed > TERM_TICKS;
    same_entry = cur.active_valid && (item.key_index == {7'd0, cur.active_entry});
  end

  always_comb begin
    mid       = cur;
    do_settle = 1'b0;
    do_emit   = 1'b0;
    do_count  = 1'b0;
    unique case (item.func)
      FUNC_PRESS: begin
        if (item.key_index < 8'(ENTRY_COUNT)) begin
          if (!cur.active_valid) begin
            mid.active_valid = 1'b1;
            mid.active_entry = item.key_index[0];
            mid.tap_count    = 2'd1;
            mid.key_down     = 1'b1;
            mid.start_tick   = item.now_ticks;
          end else if (same_entry && !cur.key_down && cur.tap_count == 2'd1) begin
            mid.tap_count  = 2'd2;
            mid.key_down   = 1'b1;
            mid.start_tick = item.now_ticks;
          end
        end
      end
      FUNC_RELEASE: begin
        if (!same_entry) begin
          mid.held_key   = '0;
          mid.layer_held = '0;
        end else if (cur.held_key != '0 || cur.layer_held != '0) begin
          mid.held_key     = '0;
          mid.layer_held   = '0;
          mid.active_valid = 1'b0;
        end else begin
          mid.key_down = 1'b0;
        end
      end
      FUNC_TICK: begin
        if (cur.active_valid && cur.key_down && term_over) begin
          do_settle = 1'b1;
        end else begin
          do_count = 1'b1;
          if (cur.active_valid && !cur.key_down && term_over) begin
            mid.active_valid = 1'b0;
            do_emit          = tap_is_key;
          end
        end
      end
      FUNC_FOREIGN: begin
        do_settle = cur.active_valid && cur.key_down && !same_entry;
      end
      default: begin
        mid = cur;
      end
    endcase

    if (do_settle) begin
      if (hold_is_layer) begin
        mid.layer_held = hold_nl;
      end else if (hold_is_key) begin
        mid.held_key = hold_kc[7:0];
      end
    end
    if (do_emit) begin
      mid.pending_tap   = tap_kc[7:0];
      mid.pending_polls = PEND_POLLS;
    end

    nxt = mid;
    if (do_count && mid.pending_polls != '0) begin
      nxt.pending_polls = mid.pending_polls - 4'd1;
      if (mid.pending_polls == 4'd1) begin
        nxt.pending_tap = '0;
      end
    end

    result.pending_key = (nxt.held_key != '0) ? nxt.held_key : nxt.pending_tap;
    result.hold_layer  = nxt.layer_held;
    result.dance_open  = nxt.active_valid;
  end

endmodule

### rtl/core/tap_dance_key_resolver.sv
// A transaction taken at the input is held in the input register, then passes
// through the decode and update logic into the output register; a stalled output
// holds it back. One transaction per cycle while the output is not stalled: the
// input register feeds one pass of decode and update logic that writes the dance
// state and the output register. Reset (rst_n low, synchronous) clears the dance
// state, all code registers and both valid flags.
module tap_dance_key_resolver import tdkr_pkg::*; #(
  parameter int ENTRY_COUNT = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CODE_W-1:0]      cfg_wdata
);

  logic [CODE_W-1:0] codes_r [ENTRY_COUNT][4];

  logic         in_vld_r;
  in_item_t     in_item_r;
  logic         out_vld_r;
  out_item_t    out_item_r;
  dance_state_t state_r;
  dance_state_t state_nxt;
  out_item_t    result_nxt;
  entry_codes_t act_codes;
  logic         step_fire;

  assign step_fire = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || step_fire;
  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  always_comb begin
    act_codes.tap      = codes_r[state_r.active_entry][CODE_TAP];
    act_codes.hold     = codes_r[state_r.active_entry][CODE_HOLD];
    act_codes.dbl      = codes_r[state_r.active_entry][CODE_DOUBLE];
    act_codes.tap_hold = codes_r[state_r.active_entry][CODE_TAP_HOLD];
  end

  tdkr_step #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_step (
    .cur    (state_r),
    .item   (in_item_r),
    .codes  (act_codes),
    .nxt    (state_nxt),
    .result (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < ENTRY_COUNT; e++) begin
        for (int f = 0; f < 4; f++) begin
          codes_r[e][f] <= '0;
        end
      end
    end else if (cfg_we && (int'(cfg_index[2]) < ENTRY_COUNT)) begin
      codes_r[cfg_index[2]][cfg_index[1:0]] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= '0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (step_fire) begin
        out_vld_r <= 1'b1;
        state_r   <= state_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
    if (step_fire) begin
      out_item_r <= result_nxt;
    end
  end

endmodule

### rtl/core/tdkr_checker.sv
`include "tap_dance_key_resolver_defines.svh"

module tdkr_checker import tdkr_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A waiting result must not change or vanish.
  `TDKR_ASSERT_NEXT(a_out_hold, clk, !rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "Stalled result transaction changed or was dropped.")

  // Reset leaves no result pending.
  `TDKR_ASSERT_NEXT(a_reset_empty, clk, 1'b0, !rst_n, !out_valid, "Result valid directly after reset.")

  // With the output register empty the input side must never stall.
  `TDKR_ASSERT_NOW(a_ready_when_empty, clk, !rst_n, !out_valid, in_ready, "Input stalled while the output register is empty.")

  // A layer can only be held while a dance is open.
  `TDKR_ASSERT_NOW(a_layer_open, clk, !rst_n, out_valid && out_data.hold_layer != 5'd0, out_data.dance_open, "Hold layer reported with no open dance.")

endmodule

bind tap_dance_key_resolver tdkr_checker u_tdkr_checker (.*);
